### rtl/lwwbt_pkg.sv
package lwwbt_pkg;

   // request kinds
   localparam logic [1:0] REQ_LOCAL_WRITE = 2'd0;
   localparam logic [1:0] REQ_PEER_MERGE  = 2'd1;
   localparam logic [1:0] REQ_READ        = 2'd2;
   // kind with no meaning, answered with a range error
   localparam logic [1:0] REQ_UNUSED      = 2'd3;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_STALE = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] entity;
      logic [15:0] byte_offset;
      logic [7:0]  data_byte;
      logic [31:0] tick;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  read_byte;
      logic [31:0] read_clock;
   } rsp_payload_type;

endpackage

### rtl/lwwbt_if.sv
interface lwwbt_req_if;
   import lwwbt_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface lwwbt_rsp_if;
   import lwwbt_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### rtl/lww_byte_table_merge.sv
// last-writer-wins byte table with peer merge
// req_chan carries one request: local write, peer merge or read of one byte
// plus the entity clock. rsp_chan returns one result per request: status,
// and for reads the stored byte and the entity clock.
// an accepted request reads both memories in the accept cycle, the data come
// back in the next cycle, where the decision is made, the memories are written
// and the result register is loaded, from which the result is visible. one
// request is in flight at a time, so a new request is taken only after the
// one before it has passed its read-then-write turn on the memories.
// req_chan.ready is held low while a request is in flight or while a result
// waits that the receiver is not taking this cycle; a stalled result holds.
// after reset a clearing pass zeroes the byte memory one entry a cycle and
// the clock memory alongside it; no request is accepted until it ends.
module lww_byte_table_merge #(
   parameter int ENTITY_COUNT = 1024,
   parameter int ROW_BYTES    = 256
) (
   input logic         clock,
   input logic         reset,
   lwwbt_req_if.sink   req_chan,
   lwwbt_rsp_if.source rsp_chan
);
   import lwwbt_pkg::*;

   localparam longint unsigned DEPTH = longint'(ENTITY_COUNT) * longint'(ROW_BYTES);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int EW = (ENTITY_COUNT > 1) ? $clog2(ENTITY_COUNT) : 1;

   // memories
   logic [7:0]  byte_store_ff   [DEPTH];
   logic [31:0] clock_store_ff  [ENTITY_COUNT];
   logic [7:0]  byte_rd_ff;
   logic [31:0] clock_rd_ff;

   // clearing pass
   logic          clearing_ff;
   logic [AW-1:0] clr_ff;

   // request in flight
   logic          s1_valid_ff;
   logic [1:0]    s1_kind_ff;
   logic          s1_err_ff;
   logic [AW-1:0] s1_addr_ff;
   logic [EW-1:0] s1_ent_ff;
   logic [7:0]    s1_data_ff;
   logic [31:0]   s1_tick_ff;

   // result register
   logic        rsp_valid_ff;
   logic [1:0]  rsp_status_ff;
   logic [7:0]  rsp_byte_ff;
   logic [31:0] rsp_clock_ff;

   logic          accept;
   logic          range_err;
   logic [31:0]   addr_full;
   logic [AW-1:0] rd_addr;
   logic [EW-1:0] rd_ent;

   logic          byte_we;
   logic [AW-1:0] byte_wa;
   logic [7:0]    byte_wd;
   logic          clock_we;
   logic [EW-1:0] clock_wa;
   logic [31:0]   clock_wd;

   logic          upd_byte;
   logic          upd_clock;
   logic [1:0]    status_in;
   logic [7:0]    rbyte_in;
   logic [31:0]   rclock_in;

   assign req_chan.ready = !clearing_ff && !s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign accept = req_chan.valid && req_chan.ready;

   // range check, the unused kind counts as a range error too
   assign range_err = (req_chan.payload.req_type == REQ_UNUSED)
      || ({1'b0, req_chan.payload.entity} >= 17'(ENTITY_COUNT))
      || ({1'b0, req_chan.payload.byte_offset} >= 17'(ROW_BYTES));

   assign addr_full = 32'(req_chan.payload.entity) * 32'(ROW_BYTES)
                    + 32'(req_chan.payload.byte_offset);
   assign rd_addr = addr_full[AW-1:0];
   assign rd_ent  = req_chan.payload.entity[EW-1:0];

   // merge decision on the data read back
   always_comb begin
      upd_byte  = 1'b0;
      upd_clock = 1'b0;
      status_in = ST_OK;
      rbyte_in  = 8'd0;
      rclock_in = 32'd0;
      if (s1_err_ff) begin
         status_in = ST_RANGE;
      end else begin
         case (s1_kind_ff)
            REQ_LOCAL_WRITE: begin
               upd_byte  = 1'b1;
               upd_clock = 1'b1;
            end
            REQ_PEER_MERGE: begin
               if (s1_tick_ff > clock_rd_ff) begin
                  upd_byte  = 1'b1;
                  upd_clock = 1'b1;
               end else if (s1_tick_ff == clock_rd_ff && s1_data_ff > byte_rd_ff) begin
                  upd_byte = 1'b1;
               end else begin
                  status_in = ST_STALE;
               end
            end
            REQ_READ: begin
               rbyte_in  = byte_rd_ff;
               rclock_in = clock_rd_ff;
            end
            default: status_in = ST_RANGE;
         endcase
      end
   end

   // write port mux: clearing pass or update
   always_comb begin
      if (clearing_ff) begin
         byte_we  = 1'b1;
         byte_wa  = clr_ff;
         byte_wd  = 8'd0;
         clock_we = ({1'b0, clr_ff} < (AW+1)'(ENTITY_COUNT));
         clock_wa = clr_ff[EW-1:0];
         clock_wd = 32'd0;
      end else begin
         byte_we  = s1_valid_ff && upd_byte;
         byte_wa  = s1_addr_ff;
         byte_wd  = s1_data_ff;
         clock_we = s1_valid_ff && upd_clock;
         clock_wa = s1_ent_ff;
         clock_wd = s1_tick_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (byte_we) begin
         byte_store_ff[byte_wa] <= byte_wd;
      end
      byte_rd_ff <= byte_store_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (clock_we) begin
         clock_store_ff[clock_wa] <= clock_wd;
      end
      clock_rd_ff <= clock_store_ff[rd_ent];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (clearing_ff) begin
            clr_ff <= clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) begin
               clearing_ff <= 1'b0;
            end
         end
         s1_valid_ff <= accept;
         if (s1_valid_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request fields held while the memories answer
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff <= req_chan.payload.req_type;
         s1_err_ff  <= range_err;
         s1_addr_ff <= rd_addr;
         s1_ent_ff  <= rd_ent;
         s1_data_ff <= req_chan.payload.data_byte;
         s1_tick_ff <= req_chan.payload.tick;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         rsp_status_ff <= status_in;
         rsp_byte_ff   <= rbyte_in;
         rsp_clock_ff  <= rclock_in;
      end
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.payload.status     = rsp_status_ff;
   assign rsp_chan.payload.read_byte  = rsp_byte_ff;
   assign rsp_chan.payload.read_clock = rsp_clock_ff;

endmodule

### rtl/lwwbt_check.sv
module lwwbt_check (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [7:0]  rsp_read_byte,
   input logic [31:0] rsp_read_clock
);
   import lwwbt_pkg::*;

   logic req_acc;
   assign req_acc = req_valid && req_ready;

   // clearing pass keeps requests out right after reset
   a_clear_blocks: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request port ready right after reset");

   // one request in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_ready)
      else $error("request accepted while another is in flight");

   // every accepted request yields a result
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_acc |-> ##2 rsp_valid)
      else $error("no result after accepted request");

   // only a successful read carries data
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_read_byte == 8'd0 && rsp_read_clock == 32'd0))
      else $error("nonzero read fields on failed request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
         && $stable(rsp_read_byte) && $stable(rsp_read_clock)))
      else $error("stalled result changed");

endmodule

bind lww_byte_table_merge lwwbt_check u_lwwbt_check (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_status     (rsp_chan.payload.status),
   .rsp_read_byte  (rsp_chan.payload.read_byte),
   .rsp_read_clock (rsp_chan.payload.read_clock)
);
